// ===== hw/rtl/dtfla_pkg.sv =====
// Package: shared types, constants and codes for the descriptor table slot allocator.
`timescale 1ns / 1ps

package dtfla_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int HEAD_W     = IDX_W + 1;
    localparam int ADDR_W     = 48;

    // Register widths
    localparam int MAX_W      = 11;
    localparam int TSIZE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int PROD_W     = TSIZE_W + IDX_W;

    // Empty marker of the freed list
    localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(SLOT_COUNT);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE    = 2'd3;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Response status codes
    localparam logic [1:0] RSP_OK    = 2'd0;
    localparam logic [1:0] RSP_EMPTY = 2'd1;
    localparam logic [1:0] RSP_RANGE = 2'd2;

    // Request transaction
    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] free_index;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  slot_index;
        logic [ADDR_W-1:0] gpu_address;
        logic [ADDR_W-1:0] cpu_address;
    } rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADDR
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_req;
        logic exec;
        logic load_rsp;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic rsp_busy;
    } sts_t;

endpackage

// ===== hw/rtl/dtfla_datapath.sv =====
// Datapath: link store, freed-list head, fresh mark, registers and address arithmetic.
`timescale 1ns / 1ps

module dtfla_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dtfla_pkg::cmd_t                       cmd,
    output dtfla_pkg::sts_t                       sts,
    input  dtfla_pkg::req_t                       req,
    output dtfla_pkg::rsp_t                       rsp,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    input  logic                                  cfg_we,
    input  logic [dtfla_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtfla_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W  = dtfla_pkg::IDX_W;
    localparam int HEAD_W = dtfla_pkg::HEAD_W;
    localparam int ADDR_W = dtfla_pkg::ADDR_W;
    localparam int PROD_W = dtfla_pkg::PROD_W;

    // Link store
    logic [HEAD_W-1:0] link_mem [dtfla_pkg::SLOT_COUNT];
    logic [HEAD_W-1:0] link_rd_reg;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr;

    // Control state
    logic [HEAD_W-1:0]              head_reg, head_next;
    logic [HEAD_W-1:0]              fresh_reg, fresh_next;
    logic [dtfla_pkg::MAX_W-1:0]    max_entries_reg;
    logic [dtfla_pkg::TSIZE_W-1:0]  table_size_reg;
    logic [ADDR_W-1:0]              gpu_base_reg;
    logic [ADDR_W-1:0]              cpu_base_reg;
    logic                           rsp_valid_reg, rsp_valid_next;

    // Payload registers
    dtfla_pkg::req_t    req_reg;
    logic [1:0]         status_reg, status_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [PROD_W-1:0]  prod_reg;
    dtfla_pkg::rsp_t    rsp_reg;

    logic [HEAD_W-1:0]  limit;
    logic [HEAD_W-1:0]  fidx_ext;

    // Effective pool size
    assign limit = (max_entries_reg > dtfla_pkg::MAX_W'(dtfla_pkg::SLOT_COUNT))
                   ? HEAD_W'(dtfla_pkg::SLOT_COUNT) : HEAD_W'(max_entries_reg);
    assign fidx_ext = {1'b0, req_reg.free_index};

    // Pop / push decision
    always_comb
    begin
        head_next   = head_reg;
        fresh_next  = fresh_reg;
        status_next = dtfla_pkg::RSP_OK;
        slot_next   = '0;
        link_we     = 1'b0;
        link_waddr  = req_reg.free_index;
        if (req_reg.mode == dtfla_pkg::MODE_FREE)
        begin
            if (fidx_ext >= limit)
            begin
                status_next = dtfla_pkg::RSP_RANGE;
            end
            else
            begin
                link_we   = cmd.exec;
                head_next = fidx_ext;
            end
        end
        else if (head_reg < limit)
        begin
            slot_next = head_reg[IDX_W-1:0];
            head_next = link_rd_reg;
        end
        else
        begin
            // No freed slot waiting: hand out a fresh one, or report empty when none is left
            head_next = dtfla_pkg::EMPTY_MARK;
            if (fresh_reg < limit)
            begin
                slot_next  = fresh_reg[IDX_W-1:0];
                fresh_next = fresh_reg + HEAD_W'(1);
            end
            else
            begin
                status_next = dtfla_pkg::RSP_EMPTY;
            end
        end
    end

    // Response valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_rsp)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= dtfla_pkg::EMPTY_MARK;
            fresh_reg       <= '0;
            max_entries_reg <= dtfla_pkg::MAX_W'(dtfla_pkg::SLOT_COUNT);
            table_size_reg  <= '0;
            gpu_base_reg    <= '0;
            cpu_base_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                fresh_reg <= fresh_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    dtfla_pkg::CFG_MAX_ENTRIES:
                    begin
                        max_entries_reg <= cfg_data[dtfla_pkg::MAX_W-1:0];
                        head_reg        <= dtfla_pkg::EMPTY_MARK;
                        fresh_reg       <= '0;
                    end
                    dtfla_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_data[dtfla_pkg::TSIZE_W-1:0];
                    dtfla_pkg::CFG_GPU_BASE:   gpu_base_reg   <= cfg_data[ADDR_W-1:0];
                    dtfla_pkg::CFG_CPU_BASE:   cpu_base_reg   <= cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Link store: write on push, registered read at the head
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= head_reg;
        link_rd_reg <= link_mem[head_reg[IDX_W-1:0]];
    end

    // Payload pipeline: request, decision plus offset, response
    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
            req_reg <= req;
        if (cmd.exec)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            prod_reg   <= PROD_W'(table_size_reg) * PROD_W'(slot_next);
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.slot_index <= slot_reg;
            if (status_reg == dtfla_pkg::RSP_OK && req_reg.mode == dtfla_pkg::MODE_ALLOC)
            begin
                rsp_reg.gpu_address <= gpu_base_reg + ADDR_W'(prod_reg);
                rsp_reg.cpu_address <= cpu_base_reg + ADDR_W'(prod_reg);
            end
            else
            begin
                rsp_reg.gpu_address <= '0;
                rsp_reg.cpu_address <= '0;
            end
        end
    end

    assign rsp          = rsp_reg;
    assign rsp_valid    = rsp_valid_reg;
    assign sts.rsp_busy = rsp_valid_reg && rsp_stall;

endmodule

// ===== hw/rtl/dtfla_ctrl.sv =====
// Controller: sequences request intake, list update and response load.
`timescale 1ns / 1ps

module dtfla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  dtfla_pkg::sts_t  sts,
    output dtfla_pkg::cmd_t  cmd
);

    dtfla_pkg::state_t state_reg, state_next;
    logic              can_take;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtfla_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = dtfla_pkg::ST_EXEC;
            end
            dtfla_pkg::ST_EXEC:
            begin
                state_next = dtfla_pkg::ST_ADDR;
            end
            dtfla_pkg::ST_ADDR:
            begin
                if (!sts.rsp_busy)
                    state_next = req_valid ? dtfla_pkg::ST_EXEC : dtfla_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dtfla_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        can_take     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_rsp = 1'b0;
        case (state_reg)
            dtfla_pkg::ST_IDLE:
            begin
                can_take = 1'b1;
            end
            dtfla_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            dtfla_pkg::ST_ADDR:
            begin
                can_take     = !sts.rsp_busy;
                cmd.load_rsp = !sts.rsp_busy;
            end
            default: ;
        endcase
        cmd.take_req = can_take && req_valid;
        req_stall    = !can_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dtfla_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/descriptor_table_free_list_allocator_unit.sv =====
// Top level: descriptor table slot allocator built from controller and datapath.
//
//  channel  direction  handshake               payload
//  req      in         req_valid / req_stall   req_t  (mode, free_index)
//  rsp      out        rsp_valid / rsp_stall   rsp_t  (status, slot_index, addresses)
//  cfg      in         cfg_we                  cfg_index, cfg_data
//
// Each transaction runs through an execute step (registered link-store read, the
// pop/push decision and the offset multiply) and an address step (base add into
// the response register). The next request is taken as the response is loaded.
// After reset the pool is ready at once; the link store is not cleared.
// A stalled response holds the block in its address step until it is taken.
`timescale 1ns / 1ps

module descriptor_table_free_list_allocator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  dtfla_pkg::req_t                   req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output dtfla_pkg::rsp_t                   rsp,
    input  logic                              cfg_we,
    input  logic [dtfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dtfla_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dtfla_pkg::cmd_t cmd;
    dtfla_pkg::sts_t sts;

    dtfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dtfla_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // An accepted request is processed in the next cycle
    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_req |=> cmd.exec)
        else $error("accepted request not processed");

    // No intake while the list update is in progress
    a_exec_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> !cmd.take_req)
        else $error("request taken during list update");

    // A response load never overwrites a stalled response and always shows up
    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rsp |-> !(rsp_valid && rsp_stall) ##1 rsp_valid)
        else $error("response overwritten or lost");

endmodule
